// ----- rtl/core/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and constants of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int DATA_WIDTH    = 16;
    localparam int FRAC_BITS_DEF = 8;
    localparam int LATENCY       = DATA_WIDTH + 6;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    typedef struct packed {
        t_op                           req_type;
        logic signed [DATA_WIDTH-1:0]  a_re;
        logic signed [DATA_WIDTH-1:0]  a_im;
        logic signed [DATA_WIDTH-1:0]  b_re;
        logic signed [DATA_WIDTH-1:0]  b_im;
    } t_req;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  res_re;
        logic signed [DATA_WIDTH-1:0]  res_im;
        t_status                       status;
    } t_res;

    // side data that travels with the divider stages
    typedef struct packed {
        logic                          is_div;
        logic                          div0;
        logic                          sat;
        logic                          neg_re;
        logic                          neg_im;
        logic                          ovf_re;
        logic                          ovf_im;
        logic signed [DATA_WIDTH-1:0]  res_re;
        logic signed [DATA_WIDTH-1:0]  res_im;
    } t_tag;

endpackage

// ----- rtl/core/cau_div_step.sv -----
// ----------------------------------------------------------------------------
// cau_div_step
// One registered restoring-division step for both result parts: develops
// one quotient bit against the shared divisor.
// ----------------------------------------------------------------------------
module cau_div_step
    import cau_pkg::*;
#(
    parameter int REM_WIDTH = 3 * DATA_WIDTH,
    parameter int BIT_POS   = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [2*DATA_WIDTH-1:0]  i_div,
    input  logic [REM_WIDTH-1:0]     i_rem_re,
    input  logic [REM_WIDTH-1:0]     i_rem_im,
    input  logic [DATA_WIDTH-1:0]    i_quo_re,
    input  logic [DATA_WIDTH-1:0]    i_quo_im,
    input  t_tag                     i_tag,
    output logic                     o_valid,
    output logic [2*DATA_WIDTH-1:0]  o_div,
    output logic [REM_WIDTH-1:0]     o_rem_re,
    output logic [REM_WIDTH-1:0]     o_rem_im,
    output logic [DATA_WIDTH-1:0]    o_quo_re,
    output logic [DATA_WIDTH-1:0]    o_quo_im,
    output t_tag                     o_tag
);

    logic [REM_WIDTH-1:0] dsh;
    logic                 ge_re;
    logic                 ge_im;

    logic                 r_valid;
    logic [2*DATA_WIDTH-1:0] r_div;
    logic [REM_WIDTH-1:0] r_rem_re;
    logic [REM_WIDTH-1:0] r_rem_im;
    logic [DATA_WIDTH-1:0] r_quo_re;
    logic [DATA_WIDTH-1:0] r_quo_im;
    t_tag                 r_tag;

    assign dsh   = REM_WIDTH'(i_div) << BIT_POS;
    assign ge_re = (i_rem_re >= dsh);
    assign ge_im = (i_rem_im >= dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div    <= i_div;
        r_rem_re <= ge_re ? (i_rem_re - dsh) : i_rem_re;
        r_rem_im <= ge_im ? (i_rem_im - dsh) : i_rem_im;
        r_quo_re <= {i_quo_re[DATA_WIDTH-2:0], ge_re};
        r_quo_im <= {i_quo_im[DATA_WIDTH-2:0], ge_im};
        r_tag    <= i_tag;
    end

    assign o_valid  = r_valid;
    assign o_div    = r_div;
    assign o_rem_re = r_rem_re;
    assign o_rem_im = r_rem_im;
    assign o_quo_re = r_quo_re;
    assign o_quo_im = r_quo_im;
    assign o_tag    = r_tag;

endmodule

// ----- rtl/core/complex_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Add, subtract, multiply or divide two complex fixed-point operands.
// ----------------------------------------------------------------------------
// A word is taken in every cycle that start is high (busy stays low) and its
// result appears on o_res with o_strobe high, whatever the operation; results
// come out in order at up to one per cycle and must be taken when shown.
// The depth is set by the divider, which develops one quotient bit per stage
// after five stages of operand, multiply, sum and scaling logic.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_req  i_req,
    output logic  o_strobe,
    output t_res  o_res
);

    localparam int W     = DATA_WIDTH;
    localparam int PW    = 2 * W + 1;
    localparam int MW    = 2 * W;
    localparam int NUM_W = 2 * W + FRAC_BITS;
    localparam int REM_W = (NUM_W > 3 * W) ? NUM_W : 3 * W;

    localparam logic signed [PW-1:0] HI_P = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [PW-1:0] LO_P = ~HI_P;
    localparam logic signed [W-1:0]  HI_W = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  LO_W = ~HI_W;
    localparam logic signed [65:0]   S64_MAX = {3'b000, {63{1'b1}}};
    localparam logic signed [65:0]   S64_MIN = ~S64_MAX;

    typedef struct packed {
        logic                 sat;
        logic signed [W-1:0]  val;
    } t_clip;

    typedef struct packed {
        logic                 sat;
        logic                 neg;
        logic [MW-1:0]        mag;
    } t_nmag;

    function automatic t_clip clip(input logic signed [PW-1:0] v);
        t_clip c;
        begin
            if (v > HI_P) begin
                c.sat = 1'b1;
                c.val = HI_W;
            end else if (v < LO_P) begin
                c.sat = 1'b1;
                c.val = LO_W;
            end else begin
                c.sat = 1'b0;
                c.val = v[W-1:0];
            end
            return c;
        end
    endfunction

    // 64-bit saturation of a numerator, then sign and magnitude
    function automatic t_nmag to_mag(input logic signed [PW-1:0] v);
        t_nmag             m;
        logic signed [65:0] e;
        logic signed [65:0] c;
        begin
            e     = 66'(v);
            m.sat = 1'b0;
            c     = e;
            if (e > S64_MAX) begin
                c     = S64_MAX;
                m.sat = 1'b1;
            end else if (e < S64_MIN) begin
                c     = S64_MIN;
                m.sat = 1'b1;
            end
            m.neg = c[65];
            m.mag = c[65] ? MW'(-c) : MW'(c);
            return m;
        end
    endfunction

    function automatic t_clip div_part(input logic [W-1:0] q, input logic ovf,
                                       input logic neg);
        t_clip c;
        begin
            c.sat = 1'b0;
            if (!neg) begin
                if (ovf || q[W-1]) begin
                    c.sat = 1'b1;
                    c.val = HI_W;
                end else begin
                    c.val = q;
                end
            end else begin
                if (ovf || (q[W-1] && (q[W-2:0] != '0))) begin
                    c.sat = 1'b1;
                    c.val = LO_W;
                end else begin
                    c.val = -q;
                end
            end
            return c;
        end
    endfunction

    // stage 1: operands
    logic                   r1_v;
    t_req                   r1_req;

    // stage 2: products, add/sub
    logic                   r2_v;
    t_op                    r2_op;
    logic signed [MW-1:0]   r2_p_rr, r2_p_ii, r2_p_ri, r2_p_ir, r2_p_bbr, r2_p_bbi;
    t_clip                  r2_as_re, r2_as_im;
    logic signed [PW-1:0]   as_re, as_im;

    // stage 3: sums
    logic                   r3_v;
    t_op                    r3_op;
    logic signed [PW-1:0]   r3_mre, r3_mim, r3_nre, r3_nim;
    logic [MW-1:0]          r3_d;
    t_clip                  r3_as_re, r3_as_im;

    // stage 4: multiply results, numerator magnitudes
    logic                   r4_v;
    t_tag                   r4_tag;
    logic [MW-1:0]          r4_mag_re, r4_mag_im;
    logic [MW-1:0]          r4_d;
    t_clip                  c_mre, c_mim;
    t_nmag                  m_re, m_im;
    t_tag                   n4_tag;

    // stage 5: scaled numerators, overflow test
    logic                   r5_v;
    t_tag                   r5_tag;
    t_tag                   n5_tag;
    logic [REM_W-1:0]       r5_rem_re, r5_rem_im;
    logic [MW-1:0]          r5_d;
    logic [REM_W-1:0]       n5_rem_re, n5_rem_im, dsh_w;

    // divider chain
    logic                   s_v      [0:W];
    logic [MW-1:0]          s_d      [0:W];
    logic [REM_W-1:0]       s_rem_re [0:W];
    logic [REM_W-1:0]       s_rem_im [0:W];
    logic [W-1:0]           s_quo_re [0:W];
    logic [W-1:0]           s_quo_im [0:W];
    t_tag                   s_tag    [0:W];

    // output
    logic                   r_strobe;
    t_res                   r_res;
    t_res                   n_res;
    t_clip                  d_re, d_im;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v     <= 1'b0;
            r2_v     <= 1'b0;
            r3_v     <= 1'b0;
            r4_v     <= 1'b0;
            r5_v     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r1_v     <= start && !busy;
            r2_v     <= r1_v;
            r3_v     <= r2_v;
            r4_v     <= r3_v;
            r5_v     <= r4_v;
            r_strobe <= s_v[W];
        end
    end

    always_comb begin
        if (r1_req.req_type == OP_SUB) begin
            as_re = PW'($signed(r1_req.a_re)) - PW'($signed(r1_req.b_re));
            as_im = PW'($signed(r1_req.a_im)) - PW'($signed(r1_req.b_im));
        end else begin
            as_re = PW'($signed(r1_req.a_re)) + PW'($signed(r1_req.b_re));
            as_im = PW'($signed(r1_req.a_im)) + PW'($signed(r1_req.b_im));
        end
    end

    always_comb begin
        c_mre = clip(r3_mre >>> FRAC_BITS);
        c_mim = clip(r3_mim >>> FRAC_BITS);
        m_re  = to_mag(r3_nre);
        m_im  = to_mag(r3_nim);
        n4_tag        = '0;
        n4_tag.is_div = (r3_op == OP_DIV);
        n4_tag.div0   = (r3_d == '0);
        n4_tag.neg_re = m_re.neg;
        n4_tag.neg_im = m_im.neg;
        case (r3_op)
            OP_ADD, OP_SUB: begin
                n4_tag.res_re = r3_as_re.val;
                n4_tag.res_im = r3_as_im.val;
                n4_tag.sat    = r3_as_re.sat | r3_as_im.sat;
            end
            OP_MUL: begin
                n4_tag.res_re = c_mre.val;
                n4_tag.res_im = c_mim.val;
                n4_tag.sat    = c_mre.sat | c_mim.sat;
            end
            OP_DIV: begin
                n4_tag.sat    = m_re.sat | m_im.sat;
            end
            default: begin
                n4_tag.sat    = 1'b0;
            end
        endcase
    end

    assign n5_rem_re = REM_W'(r4_mag_re) << FRAC_BITS;
    assign n5_rem_im = REM_W'(r4_mag_im) << FRAC_BITS;
    assign dsh_w     = REM_W'(r4_d) << W;

    always_comb begin
        n5_tag        = r4_tag;
        n5_tag.ovf_re = (n5_rem_re >= dsh_w);
        n5_tag.ovf_im = (n5_rem_im >= dsh_w);
    end

    always_ff @(posedge i_clk) begin
        r1_req    <= i_req;

        r2_op     <= r1_req.req_type;
        r2_p_rr   <= $signed(r1_req.a_re) * $signed(r1_req.b_re);
        r2_p_ii   <= $signed(r1_req.a_im) * $signed(r1_req.b_im);
        r2_p_ri   <= $signed(r1_req.a_re) * $signed(r1_req.b_im);
        r2_p_ir   <= $signed(r1_req.a_im) * $signed(r1_req.b_re);
        r2_p_bbr  <= $signed(r1_req.b_re) * $signed(r1_req.b_re);
        r2_p_bbi  <= $signed(r1_req.b_im) * $signed(r1_req.b_im);
        r2_as_re  <= clip(as_re);
        r2_as_im  <= clip(as_im);

        r3_op     <= r2_op;
        r3_mre    <= PW'(r2_p_rr) - PW'(r2_p_ii);
        r3_mim    <= PW'(r2_p_ri) + PW'(r2_p_ir);
        r3_nre    <= PW'(r2_p_rr) + PW'(r2_p_ii);
        r3_nim    <= PW'(r2_p_ir) - PW'(r2_p_ri);
        r3_d      <= $unsigned(r2_p_bbr) + $unsigned(r2_p_bbi);
        r3_as_re  <= r2_as_re;
        r3_as_im  <= r2_as_im;

        r4_tag    <= n4_tag;
        r4_mag_re <= m_re.mag;
        r4_mag_im <= m_im.mag;
        r4_d      <= r3_d;

        r5_tag        <= n5_tag;
        r5_rem_re     <= n5_rem_re;
        r5_rem_im     <= n5_rem_im;
        r5_d          <= r4_d;

        r_res     <= n_res;
    end

    assign s_v[0]      = r5_v;
    assign s_d[0]      = r5_d;
    assign s_rem_re[0] = r5_rem_re;
    assign s_rem_im[0] = r5_rem_im;
    assign s_quo_re[0] = '0;
    assign s_quo_im[0] = '0;
    assign s_tag[0]    = r5_tag;

    for (genvar k = 0; k < W; k++) begin : g_div
        cau_div_step #(
            .REM_WIDTH (REM_W),
            .BIT_POS   (W - 1 - k)
        ) u_step (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (s_v[k]),
            .i_div    (s_d[k]),
            .i_rem_re (s_rem_re[k]),
            .i_rem_im (s_rem_im[k]),
            .i_quo_re (s_quo_re[k]),
            .i_quo_im (s_quo_im[k]),
            .i_tag    (s_tag[k]),
            .o_valid  (s_v[k+1]),
            .o_div    (s_d[k+1]),
            .o_rem_re (s_rem_re[k+1]),
            .o_rem_im (s_rem_im[k+1]),
            .o_quo_re (s_quo_re[k+1]),
            .o_quo_im (s_quo_im[k+1]),
            .o_tag    (s_tag[k+1])
        );
    end

    always_comb begin
        d_re = div_part(s_quo_re[W], s_tag[W].ovf_re, s_tag[W].neg_re);
        d_im = div_part(s_quo_im[W], s_tag[W].ovf_im, s_tag[W].neg_im);
        if (!s_tag[W].is_div) begin
            n_res.res_re = s_tag[W].res_re;
            n_res.res_im = s_tag[W].res_im;
            n_res.status = s_tag[W].sat ? ST_SAT : ST_OK;
        end else if (s_tag[W].div0) begin
            n_res.res_re = '0;
            n_res.res_im = '0;
            n_res.status = ST_DIV0;
        end else begin
            n_res.res_re = d_re.val;
            n_res.res_im = d_im.val;
            n_res.status = (s_tag[W].sat || d_re.sat || d_im.sat) ? ST_SAT : ST_OK;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

// ----- rtl/core/cau_checker.sv -----
// ----------------------------------------------------------------------------
// cau_props
// Port-level checks of the complex arithmetic unit: fixed latency, result
// framing, cleared divide-by-zero results and sums.
// ----------------------------------------------------------------------------
module cau_props
    import cau_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  logic  busy,
    input  t_req  i_req,
    input  logic  o_strobe,
    input  t_res  o_res
);

    a_word_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("accepted word not returned after fixed latency");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LATENCY))
        else $error("result strobe without matching word");

    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.status == ST_DIV0)
        |-> (o_res.res_re == '0 && o_res.res_im == '0))
        else $error("divide by zero result not cleared");

    a_add_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.status == ST_OK && $past(i_req.req_type, LATENCY) == OP_ADD)
        |-> (o_res.res_re == DATA_WIDTH'($past(i_req.a_re, LATENCY)
                                         + $past(i_req.b_re, LATENCY))))
        else $error("unsaturated sum mismatch");

endmodule

bind complex_arithmetic_unit cau_props u_cau_props (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_req    (i_req),
    .o_strobe (o_strobe),
    .o_res    (o_res)
);
